### rtl/iptmu_pkg.sv
// Shared types and constants of the page table map update block.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`default_nettype none

package iptmu_pkg;

  localparam int GPA_W     = 64;
  localparam int HPA_W     = 52;
  localparam int LEN_W     = 64;
  localparam int ENTRY_W   = 64;
  localparam int IDX_W     = 9;
  localparam int PN_W      = 40;
  localparam int PN_LSB    = 12;
  localparam int SHIFT_W   = 6;
  localparam int LVL_W     = 3;
  localparam int SPMASK_W  = 4;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SP_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS  = 1'b1;

  localparam logic [LVL_W-1:0] LEVELS_RST = 3'd4;
  localparam logic [LVL_W-1:0] LEVELS_MIN = 3'd2;
  localparam logic [LVL_W-1:0] LEVELS_MAX = 3'd6;

  localparam logic [ENTRY_W-1:0] PTE_RD = 64'h1;
  localparam logic [ENTRY_W-1:0] PTE_WR = 64'h2;
  localparam logic [ENTRY_W-1:0] PTE_SP = 64'h80;

  localparam logic [SHIFT_W-1:0] SHIFT_BASE = 6'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_STEP = 6'd9;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNALIGNED = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  typedef struct packed {
    logic    capture;
    logic    setup;
    logic    clr_step;
    logic    rd_issue;
    logic    alloc;
    logic    walk;
    logic    leaf;
    logic    mod_start;
    logic    out_load;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic bad_align;
    logic at_leaf;
    logic entry_zero;
    logic exhausted;
    logic mod_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

### rtl/iommu_page_table_map_update.sv
// One request at a time: the next request is taken only after the previous result
// has been loaded into the output register.
// After reset the page store is swept to zero, with in_stall high.
// Top level: joins iptmu_ctrl and iptmu_dp; uses iptmu_pkg.
`default_nettype none

module iommu_page_table_map_update
  import iptmu_pkg::*;
#(
  parameter int NUM_PAGES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [GPA_W-1:0]     in_guest_addr,
  input  wire logic [HPA_W-1:0]     in_host_addr,
  input  wire logic [LEN_W-1:0]     in_length,
  input  wire logic                 in_unmap,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_status,
  output logic [SHIFT_W-1:0]        out_mapped_shift
);

  cmd_t cmd;
  sts_t sts;

  iptmu_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  iptmu_dp #(
    .NUM_PAGES(NUM_PAGES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_guest_addr   (in_guest_addr),
    .in_host_addr    (in_host_addr),
    .in_length       (in_length),
    .in_unmap        (in_unmap),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_mapped_shift(out_mapped_shift),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire

### rtl/iptmu_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module iptmu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/iptmu_ctrl.sv
// Controller state machine of the page table map update block.
// Sequences clearing, table walk, allocation and result hand-off; uses iptmu_pkg.
`default_nettype none

module iptmu_ctrl
  import iptmu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_WALK   = 7'b0001000,
    S_RDATA  = 7'b0010000,
    S_MODW   = 7'b0100000,
    S_RESULT = 7'b1000000
  } state_t;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    cmd            = '0;
    cmd.res_status = status_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.setup = 1'b1;
        if (sts.bad_align) begin
          status_nxt = ST_UNALIGNED;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.at_leaf) begin
          cmd.leaf   = 1'b1;
          status_nxt = ST_OK;
          state_nxt  = S_RESULT;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_RDATA;
        end
      end
      S_RDATA: begin
        if (sts.entry_zero) begin
          if (sts.exhausted) begin
            status_nxt = ST_EXHAUSTED;
            state_nxt  = S_RESULT;
          end else begin
            cmd.alloc = 1'b1;
            state_nxt = S_WALK;
          end
        end else begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_MODW;
        end
      end
      S_MODW: begin
        if (sts.mod_done) begin
          cmd.walk  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/iptmu_dp.sv
// Datapath of the page table map update block: configuration, request
// registers, page store, allocator, page number reduction and result register.
// Uses iptmu_pkg and iptmu_ram.
`default_nettype none

module iptmu_dp
  import iptmu_pkg::*;
#(
  parameter int NUM_PAGES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic [GPA_W-1:0]     in_guest_addr,
  input  wire logic [HPA_W-1:0]     in_host_addr,
  input  wire logic [LEN_W-1:0]     in_length,
  input  wire logic                 in_unmap,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_status,
  output logic [SHIFT_W-1:0]        out_mapped_shift,
  input  wire cmd_t                 cmd,
  output sts_t                      sts
);

  localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int NFW   = $clog2(NUM_PAGES + 1);
  localparam int DEPTH = NUM_PAGES * (1 << IDX_W);
  localparam int AW    = PW + IDX_W;
  localparam bit POW2  = ((NUM_PAGES & (NUM_PAGES - 1)) == 0);

  logic [SPMASK_W-1:0] sp_mask_r;
  logic [LVL_W-1:0]    levels_r;
  logic [GPA_W-1:0]    gpa_r;
  logic [HPA_W-1:0]    hpa_r;
  logic [LEN_W-1:0]    len_r;
  logic                unmap_r;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [LVL_W-1:0]    leaf_r, leaf_nxt;
  logic [PW-1:0]       page_r, page_nxt;
  logic [NFW-1:0]      nf_r, nf_nxt;
  logic [AW-1:0]       clr_addr_r;
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [SHIFT_W-1:0]  out_shift_r;

  logic [IDX_W-1:0]    idx;
  logic [LVL_W-1:0]    sp_lvl;
  logic [LVL_W-1:0]    lv_clamp;
  logic [LVL_W-1:0]    top_lvl;
  logic [ENTRY_W-1:0]  hpa_ext;
  logic [ENTRY_W-1:0]  rd_data;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [SHIFT_W-1:0]  leaf_shift;
  logic [PW-1:0]       mod_rem;
  logic                mod_done;
  logic [PN_W-1:0]     entry_pn;

  function automatic logic [ENTRY_W-1:0] sp_low_mask(input int i);
    return (64'd1 << (21 + 9 * i)) - 64'd1;
  endfunction

  function automatic logic [IDX_W-1:0] level_idx(input logic [GPA_W-1:0] a,
                                                 input logic [LVL_W-1:0] l);
    logic [IDX_W-1:0] r;
    r = '0;
    case (l)
      3'd0:    r = a[20:12];
      3'd1:    r = a[29:21];
      3'd2:    r = a[38:30];
      3'd3:    r = a[47:39];
      3'd4:    r = a[56:48];
      3'd5:    r = {2'b00, a[63:57]};
      default: r = '0;
    endcase
    return r;
  endfunction

  assign hpa_ext  = {{(ENTRY_W - HPA_W){1'b0}}, hpa_r};
  assign idx      = level_idx(gpa_r, lvl_r);
  assign entry_pn = rd_data[PN_LSB +: PN_W];

  always_comb begin
    logic found;
    found  = 1'b0;
    sp_lvl = '0;
    for (int i = SPMASK_W - 1; i >= 0; i--) begin
      if (!found && sp_mask_r[i] && ((gpa_r & sp_low_mask(i)) == '0) &&
          ((hpa_ext & sp_low_mask(i)) == '0) && ((len_r & ~sp_low_mask(i)) != '0)) begin
        found  = 1'b1;
        sp_lvl = LVL_W'(i + 1);
      end
    end
  end

  always_comb begin
    if (levels_r < LEVELS_MIN) begin
      lv_clamp = LEVELS_MIN;
    end else if (levels_r > LEVELS_MAX) begin
      lv_clamp = LEVELS_MAX;
    end else begin
      lv_clamp = levels_r;
    end
  end

  assign top_lvl    = lv_clamp - 3'd1;
  assign leaf_shift = SHIFT_BASE + SHIFT_STEP * {{(SHIFT_W - LVL_W){1'b0}}, lvl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_mask_r <= '0;
      levels_r  <= LEVELS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SP_MASK: sp_mask_r <= cfg_wdata[SPMASK_W-1:0];
        CFG_LEVELS:  levels_r  <= cfg_wdata[LVL_W-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gpa_r   <= in_guest_addr;
      hpa_r   <= in_unmap ? '0 : in_host_addr;
      len_r   <= in_length;
      unmap_r <= in_unmap;
    end
  end

  always_comb begin
    lvl_nxt  = lvl_r;
    leaf_nxt = leaf_r;
    page_nxt = page_r;
    nf_nxt   = nf_r;
    if (cmd.setup) begin
      lvl_nxt  = top_lvl;
      leaf_nxt = (sp_lvl < top_lvl) ? sp_lvl : top_lvl;
      page_nxt = '0;
    end else if (cmd.alloc) begin
      lvl_nxt  = lvl_r - 3'd1;
      page_nxt = nf_r[PW-1:0];
      nf_nxt   = nf_r + NFW'(1);
    end else if (cmd.walk) begin
      lvl_nxt  = lvl_r - 3'd1;
      page_nxt = mod_rem;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r  <= lvl_nxt;
    leaf_r <= leaf_nxt;
    page_r <= page_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r       <= NFW'(1);
      clr_addr_r <= '0;
    end else begin
      nf_r <= nf_nxt;
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_comb begin
    ram_we    = cmd.clr_step | cmd.alloc | cmd.leaf;
    ram_waddr = {page_r, idx};
    ram_wdata = '0;
    if (cmd.clr_step) begin
      ram_waddr = clr_addr_r;
    end else if (cmd.alloc) begin
      ram_wdata = ({{(ENTRY_W - NFW){1'b0}}, nf_r} << PN_LSB) | PTE_RD | PTE_WR;
    end else if (!unmap_r) begin
      ram_wdata = hpa_ext | PTE_RD | PTE_WR | ((lvl_r != '0) ? PTE_SP : '0);
    end
  end

  iptmu_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_issue),
    .raddr({page_r, idx}),
    .rdata(rd_data)
  );

  generate
    if (POW2) begin : g_mod_mask
      logic [PN_W-1:0] mod_val_r;
      always_ff @(posedge clk) begin
        if (cmd.mod_start) begin
          mod_val_r <= entry_pn;
        end
      end
      assign mod_rem  = mod_val_r[PW-1:0];
      assign mod_done = 1'b1;
    end else begin : g_mod_fold
      // Three folds bring the page number below 2^21, then a reciprocal
      // multiplication gives the quotient and one subtraction the remainder.
      localparam int FW    = 20;
      localparam int ZW    = FW + 1;
      localparam int QW    = FW;
      localparam int RS    = 33;
      localparam int PRW   = FW + PW;
      localparam int NFOLD = 3;
      localparam int CW    = 3;
      localparam logic [PW-1:0] FOLD_C  = PW'((64'd1 << FW) % NUM_PAGES);
      localparam logic [31:0]   RECIP_M =
        32'(((64'd1 << RS) + 64'(NUM_PAGES) - 64'd1) / 64'(NUM_PAGES));
      logic [PN_W-1:0] mod_val_r;
      logic [QW-1:0]   mod_q_r;
      logic [CW-1:0]   mod_cnt_r;
      logic [PRW-1:0]  fold_prod;
      logic [ZW+31:0]  recip_prod;
      logic [ZW-1:0]   q_times_n;
      assign fold_prod  = PRW'(mod_val_r[PN_W-1:FW]) * PRW'(FOLD_C);
      assign recip_prod = (ZW + 32)'(mod_val_r[ZW-1:0]) * (ZW + 32)'(RECIP_M);
      assign q_times_n  = ZW'(mod_q_r) * ZW'(NUM_PAGES);
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          mod_cnt_r <= '0;
        end else if (cmd.mod_start) begin
          mod_cnt_r <= CW'(NFOLD + 2);
        end else if (mod_cnt_r != '0) begin
          mod_cnt_r <= mod_cnt_r - CW'(1);
        end
      end
      always_ff @(posedge clk) begin
        if (cmd.mod_start) begin
          mod_val_r <= entry_pn;
        end else if (mod_cnt_r > CW'(2)) begin
          mod_val_r <= PN_W'(mod_val_r[FW-1:0]) + PN_W'(fold_prod);
        end else if (mod_cnt_r == CW'(2)) begin
          mod_q_r <= recip_prod[RS +: QW];
        end else if (mod_cnt_r == CW'(1)) begin
          mod_val_r <= PN_W'(mod_val_r[ZW-1:0] - q_times_n);
        end
      end
      assign mod_rem  = mod_val_r[PW-1:0];
      assign mod_done = (mod_cnt_r == '0);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.res_status;
      out_shift_r  <= (cmd.res_status == ST_OK) ? leaf_shift : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_mapped_shift = out_shift_r;

  assign sts.clr_last   = (clr_addr_r == AW'(DEPTH - 1));
  assign sts.bad_align  = (gpa_r[PN_LSB-1:0] != '0) || (hpa_r[PN_LSB-1:0] != '0) ||
                          (len_r[PN_LSB-1:0] != '0);
  assign sts.at_leaf    = (lvl_r == leaf_r);
  assign sts.entry_zero = (rd_data == '0);
  assign sts.exhausted  = (nf_r >= NFW'(NUM_PAGES));
  assign sts.mod_done   = mod_done;
  assign sts.out_busy   = out_valid_r && out_stall;

endmodule

`default_nettype wire

### rtl/iptmu_chk.sv
// Port-level checker of the page table map update block and its bind.
// Uses iptmu_pkg; attaches to iommu_page_table_map_update.
`default_nettype none

module iptmu_chk
  import iptmu_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         out_status,
  input wire logic [SHIFT_W-1:0] out_mapped_shift
);

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_UNALIGNED ||
                   out_status == ST_EXHAUSTED))
    else $error("Result beat carries an undefined status.");

  a_ok_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_OK) |->
      (out_mapped_shift == 6'd12 || out_mapped_shift == 6'd21 ||
       out_mapped_shift == 6'd30 || out_mapped_shift == 6'd39 ||
       out_mapped_shift == 6'd48 || out_mapped_shift == 6'd57))
    else $error("Successful beat has a shift that is not a level span.");

  a_err_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_mapped_shift == '0))
    else $error("Error beat has a nonzero shift.");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("Result appeared one cycle after an input beat.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
                                  $stable(out_mapped_shift)))
    else $error("Stalled result beat changed.");

endmodule

bind iommu_page_table_map_update iptmu_chk u_chk (.*);

`default_nettype wire

### test/tb_iommu_page_table_map_update.sv
// Self-checking testbench for the page table map update block: directed table, then random
// request phases under several superpage masks and level counts, with bursty traffic.
// Depends on iptmu_pkg and iommu_page_table_map_update.
`default_nettype none

module tb_iommu_page_table_map_update;
  import iptmu_pkg::*;

  localparam int NUM_PAGES = 64;
  localparam int PT_ENTRIES = NUM_PAGES * 512;
  localparam int CFGD_W = (SPMASK_W > CFG_W) ? SPMASK_W : CFG_W;
  localparam logic [ENTRY_W-1:0] PTE_ADDR = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] IDX_MASK = 64'h1FF;
  localparam int TOP_SP_SHIFT = 48;
  localparam int DIR_N = 25;
  localparam int N_RANDOM = 950;
  localparam int N_PHASES = 8;
  localparam int SETTLE = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT = 600000;

  typedef struct packed {
    logic [GPA_W-1:0] gpa;
    logic [HPA_W-1:0] hpa;
    logic [LEN_W-1:0] len;
    logic             unmap;
  } map_req_t;

  typedef struct packed {
    status_t            status;
    logic [SHIFT_W-1:0] shift;
  } map_res_t;

  typedef struct packed {
    logic                set_cfg;
    logic [SPMASK_W-1:0] mask;
    logic [LVL_W-1:0]    lvls;
    map_req_t            req;
    logic                typed;
    map_res_t            res;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFGD_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [GPA_W-1:0]     in_guest_addr;
  logic [HPA_W-1:0]     in_host_addr;
  logic [LEN_W-1:0]     in_length;
  logic                 in_unmap;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_status;
  logic [SHIFT_W-1:0]   out_mapped_shift;

  logic [ENTRY_W-1:0]  pt_store [PT_ENTRIES];
  int                  next_page;
  logic [SPMASK_W-1:0] sp_mask_reg;
  logic [LVL_W-1:0]    levels_reg;
  map_res_t            map_results_q [$];
  dir_row_t            dir_tab [DIR_N];
  int                  burst_left;
  int                  fail_cnt = 0;

  logic [SPMASK_W-1:0] ph_mask [7] = '{4'hF, 4'h0, 4'h5, 4'hA, 4'hF, 4'h3, 4'hC};
  logic [LVL_W-1:0]    ph_lvls [7] = '{3'd4, 3'd2, 3'd3, 3'd5, 3'd6, 3'd1, 3'd7};

  iommu_page_table_map_update #(
    .NUM_PAGES(NUM_PAGES)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_data[CFG_W-1:0]),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_guest_addr   (in_guest_addr),
    .in_host_addr    (in_host_addr),
    .in_length       (in_length),
    .in_unmap        (in_unmap),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_mapped_shift(out_mapped_shift)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic map_res_t update_page_table(input map_req_t r);
    map_res_t         res;
    logic [63:0]      hpa;
    logic [63:0]      span_m;
    logic [63:0]      pte;
    int               top;
    int               sp_shift;
    int               shift;
    int               idx;
    int               page;
    int               slot;
    int               lvl;
    int               i;
    hpa = r.unmap ? 64'd0 : 64'(r.hpa);
    res.status = ST_OK;
    res.shift = '0;
    if (r.gpa[11:0] != 0 || hpa[11:0] != 0 || r.len[11:0] != 0) begin
      res.status = ST_UNALIGNED;
      return res;
    end
    top = int'(levels_reg);
    if (top < int'(LEVELS_MIN)) top = int'(LEVELS_MIN);
    if (top > int'(LEVELS_MAX)) top = int'(LEVELS_MAX);
    sp_shift = TOP_SP_SHIFT;
    for (i = 3; i >= 0; i--) begin
      span_m = (64'd1 << sp_shift) - 64'd1;
      if (sp_mask_reg[i] && (r.gpa & span_m) == 0 && (hpa & span_m) == 0 && r.len > span_m)
        break;
      sp_shift -= int'(SHIFT_STEP);
    end
    page = 0;
    idx = 0;
    shift = int'(SHIFT_BASE);
    for (lvl = top - 1; lvl >= 0; lvl--) begin
      shift = int'(SHIFT_BASE) + lvl * int'(SHIFT_STEP);
      idx = int'((r.gpa >> shift) & IDX_MASK);
      if (sp_shift >= shift) break;
      slot = page * 512 + idx;
      if (pt_store[slot] == 0) begin
        if (next_page >= NUM_PAGES) begin
          res.status = ST_EXHAUSTED;
          return res;
        end
        pt_store[slot] = (64'(next_page) << 12) | PTE_RD | PTE_WR;
        next_page++;
      end
      page = int'(((pt_store[slot] & PTE_ADDR) >> 12) % 64'(NUM_PAGES));
    end
    slot = page * 512 + idx;
    if (r.unmap) begin
      pt_store[slot] = '0;
    end else begin
      pte = hpa | PTE_RD | PTE_WR;
      if (lvl > 0) pte |= PTE_SP;
      pt_store[slot] = pte;
    end
    res.shift = SHIFT_W'(shift);
    return res;
  endfunction

  function automatic map_req_t rand_req();
    map_req_t    r;
    logic [63:0] g;
    logic [63:0] h;
    logic [63:0] l;
    logic [63:0] keep;
    int          leaf;
    int          k;
    g = {$urandom, $urandom};
    for (k = 0; k < 5; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: g[12 + 9 * k +: 9] = 9'd0;
        4, 5:       g[12 + 9 * k +: 9] = 9'd1;
        6:          g[12 + 9 * k +: 9] = 9'h1FF;
        default:    g[12 + 9 * k +: 9] = 9'($urandom_range(0, 511));
      endcase
    end
    if ($urandom_range(0, 2) != 0) g[63:57] = 7'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: leaf = 0;
      4, 5:       leaf = 1;
      6:          leaf = 2;
      7:          leaf = 3;
      8:          leaf = 4;
      default:    leaf = 5;
    endcase
    keep = ~((64'd1 << (12 + 9 * leaf)) - 64'd1);
    g &= keep;
    h = {$urandom, $urandom} & PTE_ADDR;
    if ($urandom_range(0, 3) != 0) h &= keep;
    case ($urandom_range(0, 5))
      0:       l = 64'($urandom_range(1, 16)) << 12;
      1:       l = 64'd1 << (12 + 9 * leaf);
      2:       l = (64'd1 << (12 + 9 * leaf)) - 64'h1000;
      3:       l = {$urandom, $urandom} & ~64'hFFF;
      4:       l = '0;
      default: l = ~64'hFFF;
    endcase
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 2))
        0:       g[11:0] = 12'($urandom_range(1, 4095));
        1:       h[11:0] = 12'($urandom_range(1, 4095));
        default: l[11:0] = 12'($urandom_range(1, 4095));
      endcase
    end
    r.gpa = g;
    r.hpa = h[HPA_W-1:0];
    r.len = l;
    r.unmap = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  function automatic dir_row_t drow(input logic set_cfg, input logic [SPMASK_W-1:0] mask,
                                    input logic [LVL_W-1:0] lvls, input logic [GPA_W-1:0] g,
                                    input logic [HPA_W-1:0] h, input logic [LEN_W-1:0] l,
                                    input logic u, input logic typed, input status_t st,
                                    input logic [SHIFT_W-1:0] sh);
    dir_row_t row;
    row.set_cfg = set_cfg;
    row.mask = mask;
    row.lvls = lvls;
    row.req.gpa = g;
    row.req.hpa = h;
    row.req.len = l;
    row.req.unmap = u;
    row.typed = typed;
    row.res.status = st;
    row.res.shift = sh;
    return row;
  endfunction

  task automatic offer(input map_req_t r, input logic typed, input map_res_t typed_res);
    map_res_t e;
    in_guest_addr <= r.gpa;
    in_host_addr <= r.hpa;
    in_length <= r.len;
    in_unmap <= r.unmap;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    e = update_page_table(r);
    if (typed) e = typed_res;
    map_results_q.push_back(e);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (map_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [SPMASK_W-1:0] mask, input logic [LVL_W-1:0] lvls);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_SP_MASK;
    cfg_data <= CFGD_W'(mask);
    @(posedge clk);
    sp_mask_reg = mask;
    cfg_index <= CFG_LEVELS;
    cfg_data <= CFGD_W'(lvls);
    @(posedge clk);
    levels_reg = lvls;
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    map_res_t no_res;
    int       i;
    int       k;
    int       p;
    int       n;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_SP_MASK;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_guest_addr <= '0;
    in_host_addr <= '0;
    in_length <= '0;
    in_unmap <= 1'b0;
    rst_n <= 1'b0;
    no_res = '0;
    for (i = 0; i < PT_ENTRIES; i++) pt_store[i] = '0;
    next_page = 1;
    sp_mask_reg = '0;
    levels_reg = LEVELS_RST;
    burst_left = 0;

    dir_tab[0] = drow(1'b0, 4'h0, 3'd4, 64'h0, 52'h0, 64'h1000, 1'b0, 1'b1, ST_OK, 6'd12);
    dir_tab[1] = drow(1'b0, 4'h0, 3'd4, '1, 52'h0, 64'h0, 1'b0, 1'b1, ST_UNALIGNED, 6'd0);
    dir_tab[2] = drow(1'b0, 4'h0, 3'd4, 64'h0, '1, 64'h1000, 1'b0, 1'b1, ST_UNALIGNED, 6'd0);
    dir_tab[3] = drow(1'b0, 4'h0, 3'd4, 64'h0, 52'h0, '1, 1'b0, 1'b1, ST_UNALIGNED, 6'd0);
    dir_tab[4] = drow(1'b0, 4'h0, 3'd4, 64'h0, '1, 64'h1000, 1'b1, 1'b1, ST_OK, 6'd12);
    dir_tab[5] = drow(1'b0, 4'h0, 3'd4, 64'hFFFF_FFFF_FFFF_F000, 52'hF_FFFF_FFFF_F000,
                      64'h1000, 1'b0, 1'b1, ST_OK, 6'd12);
    dir_tab[6] = drow(1'b1, 4'hF, 3'd4, 64'h0, 52'h0, 64'hFFFF_FFFF_FFFF_F000,
                      1'b0, 1'b1, ST_OK, 6'd39);
    dir_tab[7] = drow(1'b0, 4'hF, 3'd4, 64'h20_0000, 52'h20_0000, 64'h20_0000,
                      1'b0, 1'b0, ST_OK, 6'd0);
    dir_tab[8] = drow(1'b0, 4'hF, 3'd4, 64'h40_0000, 52'h40_0000, 64'h1F_F000,
                      1'b0, 1'b0, ST_OK, 6'd0);
    dir_tab[9] = drow(1'b0, 4'hF, 3'd4, 64'h0, 52'h0, 64'hFFFF_FFFF_FFFF_F000,
                      1'b1, 1'b0, ST_OK, 6'd0);
    dir_tab[10] = drow(1'b1, 4'hF, 3'd6, 64'h0, 52'h0, 64'hFFFF_FFFF_FFFF_F000,
                       1'b0, 1'b1, ST_OK, 6'd48);
    dir_tab[11] = drow(1'b1, 4'h4, 3'd7, 64'h80_0000_0000, 52'h80_0000_0000,
                       64'h100_0000_0000, 1'b0, 1'b0, ST_OK, 6'd0);
    dir_tab[12] = drow(1'b1, 4'h2, 3'd0, 64'h4000_0000, 52'h0, 64'h4000_0000,
                       1'b0, 1'b1, ST_OK, 6'd21);
    // Fresh top-level slots at six levels use up the page store.
    for (k = 3; k <= 14; k++)
      dir_tab[10 + k] = drow(k == 3, 4'h0, 3'd6, 64'(k) << 57, 52'(k) << 12, 64'h1000,
                             1'b0, 1'b0, ST_OK, 6'd0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].set_cfg) begin
        wait_idle();
        write_cfg(dir_tab[i].mask, dir_tab[i].lvls);
      end
      offer(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
    end

    for (p = 0; p < N_PHASES; p++) begin
      wait_idle();
      if (p < 7) write_cfg(ph_mask[p], ph_lvls[p]);
      else write_cfg(SPMASK_W'($urandom_range(0, 15)), LVL_W'($urandom_range(0, 7)));
      for (n = 0; n < N_RANDOM / N_PHASES; n++) offer(rand_req(), 1'b0, no_res);
    end

    wait_idle();
    if (fail_cnt == 0) $display("tb_iommu_page_table_map_update OK");
    else $display("tb_iommu_page_table_map_update NOT OK");
    $finish;
  end

  initial begin
    map_res_t e;
    int       hold_left;
    int       mode;
    int       mode_left;
    int       results_seen;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    results_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (map_results_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected result beat: status %0d shift %0d",
                     out_status, out_mapped_shift);
        end else begin
          e = map_results_q.pop_front();
          if (out_status !== e.status || out_mapped_shift !== e.shift) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("result %0d: expected status %0d shift %0d, got status %0d shift %0d",
                       results_seen, e.status, e.shift, out_status, out_mapped_shift);
          end
        end
        results_seen++;
        if (results_seen == 200 || results_seen == 560) hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  initial begin
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_iommu_page_table_map_update NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
